// ===== hdl/htfd_pkg.sv =====
// Shared types, constants and the hex digit decoder for the hex text frame deframer.
// No dependencies; used by htfd_parser and hex_text_frame_deframer.
package htfd_pkg;

	localparam logic [7:0] FRAME_MARK = 8'h3A;
	localparam int HEADER_LEN = 7;
	localparam int HEADER_W = HEADER_LEN * 8;
	localparam logic [4:0] HEADER_CHARS = 5'd14;
	localparam int COUNT_W = 18;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HEADER,
		PH_BODY,
		PH_DROP
	} phase_t;

	typedef enum logic [1:0] {
		ST_SUM_OK,
		ST_SUM_BAD,
		ST_BODY_BAD,
		ST_HEAD_DROP
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  source;
		logic [15:0] destination;
		logic [7:0]  opcode;
		logic [15:0] payload_length;
		logic [15:0] computed_sum;
		logic [15:0] received_sum;
	} result_t;

	// Case-insensitive hex digit; anything else decodes as zero.
	function automatic logic [3:0] digit_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = 4'(c - 8'h37);
		end
		return v;
	endfunction

endpackage

// ===== hdl/htfd_parser.sv =====
// Frame parser: phase state machine, header and checksum registers.
// Depends on htfd_pkg. Consumes one registered character per step.
module htfd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        char_in,
	input  logic              chunk_end,
	input  logic              link_drop,
	output logic              res_valid,
	output htfd_pkg::result_t res
);

	localparam int CW = htfd_pkg::COUNT_W;
	localparam int HW = htfd_pkg::HEADER_W;

	htfd_pkg::phase_t phase_q, phase_d;
	logic [CW-1:0] count_q, count_d;
	logic [3:0]    high_q, high_d;
	logic [HW-1:0] header_q, header_d;
	logic [15:0]   run_q, run_d;
	logic [15:0]   trail_q, trail_d;
	logic          colon_q, colon_d;

	logic          is_colon;
	logic [3:0]    dv;
	logic [7:0]    byte_v;
	logic [CW-1:0] count_inc;
	logic [15:0]   len;
	logic [CW-1:0] total;
	logic          hdr_done;
	logic          body_done;

	assign is_colon  = (char_in == htfd_pkg::FRAME_MARK);
	assign dv        = htfd_pkg::digit_value(char_in);
	assign byte_v    = {high_q, dv};
	assign count_inc = count_q + CW'(1);
	assign len       = header_q[15:0];
	// Body length in characters: payload plus two checksum bytes, two digits each.
	assign total     = {1'b0, len, 1'b0} + CW'(4);
	assign hdr_done  = (count_inc >= CW'(htfd_pkg::HEADER_CHARS));
	assign body_done = (count_inc >= total);

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (link_drop) begin
			phase_d = htfd_pkg::PH_HUNT;
		end else begin
			case (phase_q)
				htfd_pkg::PH_HUNT: begin
					if (is_colon) phase_d = htfd_pkg::PH_HEADER;
				end
				htfd_pkg::PH_HEADER: begin
					if (is_colon) begin
						phase_d = chunk_end ? htfd_pkg::PH_HUNT : htfd_pkg::PH_DROP;
					end else if (hdr_done) begin
						phase_d = htfd_pkg::PH_BODY;
					end
				end
				htfd_pkg::PH_BODY: begin
					if (body_done) phase_d = htfd_pkg::PH_HUNT;
				end
				htfd_pkg::PH_DROP: begin
					if (chunk_end) phase_d = htfd_pkg::PH_HUNT;
				end
				default: phase_d = htfd_pkg::PH_HUNT;
			endcase
		end
	end

	// Data registers and result.
	always_comb begin
		count_d   = count_q;
		high_d    = high_q;
		header_d  = header_q;
		run_d     = run_q;
		trail_d   = trail_q;
		colon_d   = colon_q;
		res_valid = 1'b0;
		res       = '0;
		if (link_drop) begin
			count_d  = '0;
			high_d   = '0;
			header_d = '0;
			run_d    = '0;
			trail_d  = '0;
			colon_d  = 1'b0;
		end else begin
			case (phase_q)
				htfd_pkg::PH_HUNT: begin
					if (is_colon) begin
						count_d  = '0;
						high_d   = '0;
						header_d = '0;
						run_d    = '0;
						trail_d  = '0;
						colon_d  = 1'b0;
					end
				end
				htfd_pkg::PH_HEADER: begin
					if (is_colon) begin
						count_d    = '0;
						high_d     = '0;
						header_d   = '0;
						run_d      = '0;
						trail_d    = '0;
						colon_d    = 1'b0;
						res_valid  = 1'b1;
						res.status = htfd_pkg::ST_HEAD_DROP;
					end else begin
						if (!count_q[0]) begin
							high_d = dv;
						end else begin
							header_d = {header_q[HW-9:0], byte_v};
							run_d    = run_q + {8'd0, byte_v};
						end
						count_d = hdr_done ? '0 : count_inc;
					end
				end
				htfd_pkg::PH_BODY: begin
					if (is_colon) begin
						colon_d = 1'b1;
					end else if (!count_q[0]) begin
						high_d = dv;
					end else if (count_q[CW-1:1] < {1'b0, len}) begin
						run_d = run_q + {8'd0, byte_v};
					end else begin
						trail_d = {trail_q[7:0], byte_v};
					end
					count_d = count_inc;
					if (body_done) begin
						res_valid          = 1'b1;
						res.source         = header_q[47:40];
						res.destination    = header_q[39:24];
						res.opcode         = header_q[23:16];
						res.payload_length = header_q[15:0];
						if (colon_d) begin
							res.status = htfd_pkg::ST_BODY_BAD;
						end else begin
							res.status       = (run_d == trail_d) ? htfd_pkg::ST_SUM_OK
							                                      : htfd_pkg::ST_SUM_BAD;
							res.computed_sum = run_d;
							res.received_sum = trail_d;
						end
						count_d  = '0;
						high_d   = '0;
						header_d = '0;
						run_d    = '0;
						trail_d  = '0;
						colon_d  = 1'b0;
					end
				end
				htfd_pkg::PH_DROP: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= htfd_pkg::PH_HUNT;
			count_q  <= '0;
			high_q   <= '0;
			header_q <= '0;
			run_q    <= '0;
			trail_q  <= '0;
			colon_q  <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			high_q   <= high_d;
			header_q <= header_d;
			run_q    <= run_d;
			trail_q  <= trail_d;
			colon_q  <= colon_d;
		end
	end

endmodule

// ===== hdl/hex_text_frame_deframer.sv =====
// A frame's last character waits in the input register until the parser steps on it; the
// report it completes is registered in the result register and presented from there.
// Throughput: one character per cycle; the input stalls only while a report waits for
// out_ready.
// Reset (arst_n low, asynchronous) empties both registers and returns the parser to hunting
// with all header, sum and count state cleared. Depends on htfd_pkg and htfd_parser.
module hex_text_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_in,
	input  logic        chunk_end,
	input  logic        link_drop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  source,
	output logic [15:0] destination,
	output logic [7:0]  opcode,
	output logic [15:0] payload_length,
	output logic [15:0] computed_sum,
	output logic [15:0] received_sum
);

	// Input register: holds one transferred character until the parser can take it.
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       end_s1;
	logic       drop_s1;

	// Result register.
	logic              valid_s2;
	htfd_pkg::result_t res_s2;

	logic              step;
	logic              res_valid;
	htfd_pkg::result_t res;

	// The parser advances whenever a character is waiting and the result register is
	// free or being emptied this cycle, so a result never overwrites an untaken one.
	assign step     = valid_s1 && (!valid_s2 || out_ready);
	// A new character can enter while the previous one moves into the parser.
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_in;
			end_s1  <= chunk_end;
			drop_s1 <= link_drop;
		end
	end

	htfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.char_in   (char_s1),
		.chunk_end (end_s1),
		.link_drop (drop_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Most characters produce no report; the result register only fills on a
	// frame end or a dropped header.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= res_valid;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign status         = res_s2.status;
	assign source         = res_s2.source;
	assign destination    = res_s2.destination;
	assign opcode         = res_s2.opcode;
	assign payload_length = res_s2.payload_length;
	assign computed_sum   = res_s2.computed_sum;
	assign received_sum   = res_s2.received_sum;

endmodule

// ===== tb/hex_text_frame_deframer_test.sv =====
// Self-checking testbench for hex_text_frame_deframer: drives hex text frames, broken frames
// and noise, and compares every frame report against a cycle-free software deframer.
// Depends on htfd_pkg and the RTL of hex_text_frame_deframer.
module hex_text_frame_deframer_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  char_in;
	logic        chunk_end;
	logic        link_drop;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [7:0]  source;
	logic [15:0] destination;
	logic [7:0]  opcode;
	logic [15:0] payload_length;
	logic [15:0] computed_sum;
	logic [15:0] received_sum;

	hex_text_frame_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_in(char_in),
		.chunk_end(chunk_end),
		.link_drop(link_drop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.source(source),
		.destination(destination),
		.opcode(opcode),
		.payload_length(payload_length),
		.computed_sum(computed_sum),
		.received_sum(received_sum)
	);

	// Free-running 50 MHz clock.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Frame reports the deframer owes us, oldest first.
	htfd_pkg::result_t expected_reports[$];
	htfd_pkg::result_t report_due;
	int      mismatch_count = 0;

	// Knobs shared by the stimulus tasks and the receiver process.
	bit      send_gaps = 1'b1;
	bit      recv_gaps = 1'b1;
	int      chunk_pct = 10;
	int      hold_request = 0;
	int      stall_left = 0;

	// Text of the frame being built, one ASCII character per entry.
	logic [7:0] frame_text[$];

	// Software copy of the parser state.
	htfd_pkg::phase_t ph;
	logic [17:0] cnt;
	logic [3:0]  nib_hi;
	logic [55:0] hdr;
	logic [15:0] sum_run;
	logic [15:0] sum_trl;
	logic        colon_seen;

	function automatic bit is_hex_char(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	// Letters of either case share their low nibble, so bit 6 tells letter from digit.
	function automatic logic [3:0] hex_digit(input logic [7:0] c);
		if (!is_hex_char(c))
			return 4'd0;
		return c[6] ? c[3:0] + 4'd9 : c[3:0];
	endfunction

	function automatic void parser_clear();
		ph = htfd_pkg::PH_HUNT;
		cnt = '0;
		nib_hi = '0;
		hdr = '0;
		sum_run = '0;
		sum_trl = '0;
		colon_seen = 1'b0;
	endfunction

	// Advances the software parser by one transferred character and queues any report
	// that the character completes.
	task automatic deframe_char(input logic [7:0] c, input logic e, input logic d);
		htfd_pkg::result_t r;
		logic [7:0] b;
		int         total;
		r = '0;
		// A lost link wins over everything and silently resets the parser.
		if (d) begin
			parser_clear();
			return;
		end
		case (ph)
			htfd_pkg::PH_HUNT: begin
				if (c == htfd_pkg::FRAME_MARK) begin
					parser_clear();
					ph = htfd_pkg::PH_HEADER;
				end
			end
			htfd_pkg::PH_HEADER: begin
				if (c == htfd_pkg::FRAME_MARK) begin
					// A colon in the header aborts the frame at once; the rest of the
					// chunk is thrown away unless this colon already ends it.
					parser_clear();
					ph = e ? htfd_pkg::PH_HUNT : htfd_pkg::PH_DROP;
					r.status = htfd_pkg::ST_HEAD_DROP;
					expected_reports.insert(expected_reports.size(), r);
				end else begin
					if (!cnt[0]) begin
						nib_hi = hex_digit(c);
					end else begin
						b = {nib_hi, hex_digit(c)};
						hdr = {hdr[47:0], b};
						sum_run += b;
					end
					cnt++;
					if (cnt >= htfd_pkg::HEADER_CHARS) begin
						ph = htfd_pkg::PH_BODY;
						cnt = '0;
					end
				end
			end
			htfd_pkg::PH_BODY: begin
				total = (int'(hdr[15:0]) + 2) * 2;
				// A colon in the body uses up a character slot without adding a digit.
				if (c == htfd_pkg::FRAME_MARK) begin
					colon_seen = 1'b1;
				end else if (!cnt[0]) begin
					nib_hi = hex_digit(c);
				end else begin
					b = {nib_hi, hex_digit(c)};
					if (int'(cnt >> 1) < int'(hdr[15:0]))
						sum_run += b;
					else
						sum_trl = {sum_trl[7:0], b};
				end
				cnt++;
				if (int'(cnt) >= total) begin
					if (colon_seen) begin
						r.status = htfd_pkg::ST_BODY_BAD;
					end else begin
						r.status = (sum_run == sum_trl) ? htfd_pkg::ST_SUM_OK
							: htfd_pkg::ST_SUM_BAD;
						r.computed_sum = sum_run;
						r.received_sum = sum_trl;
					end
					r.source = hdr[47:40];
					r.destination = hdr[39:24];
					r.opcode = hdr[23:16];
					r.payload_length = hdr[15:0];
					expected_reports.insert(expected_reports.size(), r);
					parser_clear();
				end
			end
			default: begin
				if (e)
					ph = htfd_pkg::PH_HUNT;
			end
		endcase
	endtask

	// Receiver: out_ready changes on the falling edge. Random stalls come in bursts, and a
	// long hold-off requested by a test is counted out here, cycle by cycle.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else if (hold_request > 0) begin
				out_ready = 1'b0;
				stall_left = hold_request - 1;
				hold_request = 0;
			end else if (recv_gaps && $urandom_range(0, 7) == 0) begin
				out_ready = 1'b0;
				stall_left = $urandom_range(0, 13);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Every report transfer is matched against the oldest owed report.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_reports.size() == 0) begin
				$display("%0t ns: report with no frame behind it, status %h source %h",
					$time, status, source);
				mismatch_count++;
			end else begin
				report_due = expected_reports.pop_front();
				check_field("status", 16'(report_due.status), 16'(status));
				check_field("source", 16'(report_due.source), 16'(source));
				check_field("destination", report_due.destination, destination);
				check_field("opcode", 16'(report_due.opcode), 16'(opcode));
				check_field("payload_length", report_due.payload_length, payload_length);
				check_field("computed_sum", report_due.computed_sum, computed_sum);
				check_field("received_sum", report_due.received_sum, received_sum);
			end
		end
	end

	// Offers one character and returns on the falling edge after its transfer. in_valid is
	// left high so that a following character can go out without a bubble.
	task automatic send_char(input logic [7:0] c, input logic e, input logic d);
		if (send_gaps && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid = 1'b1;
		char_in = c;
		chunk_end = e;
		link_drop = d;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		deframe_char(c, e, d);
		@(negedge clk);
	endtask

	// The sender stops and waits until every owed report has come out.
	task automatic wait_drain();
		in_valid = 1'b0;
		while (expected_reports.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10)
			return 8'h30 + 8'(v);
		return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
	endfunction

	function automatic void add_text_char(input logic [7:0] c);
		frame_text.insert(frame_text.size(), c);
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		add_text_char(hex_char(b[7:4]));
		add_text_char(hex_char(b[3:0]));
	endfunction

	function automatic logic [7:0] junk_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (is_hex_char(c) || c == htfd_pkg::FRAME_MARK);
		return c;
	endfunction

	// Builds one frame as text and sends it. The optional positions (index into the text,
	// the leading colon at 0) overwrite a character with a colon or a non-hex character,
	// or send a link drop there and abandon the rest of the frame.
	task automatic send_frame(input logic [7:0] src, input logic [15:0] dst,
		input logic [7:0] opc, input logic [15:0] len, input bit bad_sum,
		input int colon_at = -1, input int junk_at = -1, input int drop_at = -1);
		logic [7:0]  hb[7];
		logic [7:0]  b;
		logic [15:0] sum;
		logic [15:0] trailer;
		logic        e;
		logic        d;
		hb[0] = 8'($urandom_range(0, 255));
		hb[1] = src;
		hb[2] = dst[15:8];
		hb[3] = dst[7:0];
		hb[4] = opc;
		hb[5] = len[15:8];
		hb[6] = len[7:0];
		sum = '0;
		frame_text.delete();
		add_text_char(htfd_pkg::FRAME_MARK);
		for (int i = 0; i < htfd_pkg::HEADER_LEN; i++) begin
			push_byte(hb[i]);
			sum += hb[i];
		end
		for (int i = 0; i < int'(len); i++) begin
			b = 8'($urandom_range(0, 255));
			push_byte(b);
			sum += b;
		end
		trailer = bad_sum ? sum ^ 16'($urandom_range(1, 65535)) : sum;
		push_byte(trailer[15:8]);
		push_byte(trailer[7:0]);
		if (colon_at > 0 && colon_at < frame_text.size())
			frame_text[colon_at] = htfd_pkg::FRAME_MARK;
		if (junk_at > 0 && junk_at < frame_text.size())
			frame_text[junk_at] = junk_char();
		for (int i = 0; i < frame_text.size(); i++) begin
			if (i == frame_text.size() - 1)
				e = chunk_pct >= 100 || $urandom_range(0, 3) != 0;
			else
				e = $urandom_range(1, 100) <= chunk_pct;
			d = (i == drop_at);
			send_char(frame_text[i], e, d);
			if (d)
				break;
		end
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 8))
			send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
				$urandom_range(0, 15) == 0);
	endtask

	// Hand-picked frames: field extremes, each status, and the odd corners of the parser.
	task automatic test_directed_cases();
		chunk_pct = 0;
		// Anything but a colon is skipped while hunting, chunk end included.
		send_char(8'h5A, 1'b0, 1'b0);
		send_char(8'hFF, 1'b1, 1'b0);
		send_char(8'h00, 1'b0, 1'b0);
		send_frame(8'hFF, 16'hFFFF, 8'h00, 16'd0, 1'b0);
		send_frame(8'h00, 16'h0000, 8'hFF, 16'd3, 1'b1);
		// Colon in the body: the frame runs to its full length and is flagged malformed.
		send_frame(8'h5C, 16'h1234, 8'h42, 16'd2, 1'b0, 17);
		// Non-hex characters decode as zero, in the header and in the body.
		send_frame(8'h11, 16'h2233, 8'h44, 16'd1, 1'b0, -1, 5);
		send_frame(8'h66, 16'h7788, 8'h99, 16'd1, 1'b0, -1, 16);
		// Chunk ends in the middle of a frame change nothing.
		chunk_pct = 100;
		send_frame(8'hA1, 16'hB2C3, 8'hD4, 16'd2, 1'b0);
		chunk_pct = 0;
		// Colon in the header without chunk end: everything up to the chunk end is
		// dropped, a further colon included.
		send_char(htfd_pkg::FRAME_MARK, 1'b0, 1'b0);
		send_char(8'h31, 1'b0, 1'b0);
		send_char(htfd_pkg::FRAME_MARK, 1'b0, 1'b0);
		send_char(htfd_pkg::FRAME_MARK, 1'b0, 1'b0);
		send_char(8'h37, 1'b1, 1'b0);
		send_frame(8'h01, 16'h0203, 8'h04, 16'd0, 1'b0);
		// Colon in the header that itself ends the chunk: hunting resumes at once.
		send_char(htfd_pkg::FRAME_MARK, 1'b0, 1'b0);
		send_char(8'h41, 1'b0, 1'b0);
		send_char(htfd_pkg::FRAME_MARK, 1'b1, 1'b0);
		send_frame(8'h10, 16'h2030, 8'h40, 16'd1, 1'b0);
		// Link drop in the header, in the body, on a colon and in the drop state.
		send_frame(8'h12, 16'h3456, 8'h78, 16'd4, 1'b0, -1, -1, 12);
		send_frame(8'h12, 16'h3456, 8'h78, 16'd4, 1'b0, -1, -1, 25);
		send_char(htfd_pkg::FRAME_MARK, 1'b0, 1'b1);
		send_char(8'h30, 1'b0, 1'b0);
		send_char(htfd_pkg::FRAME_MARK, 1'b0, 1'b0);
		send_char(htfd_pkg::FRAME_MARK, 1'b0, 1'b0);
		send_char(8'h31, 1'b1, 1'b1);
		send_frame(8'h9A, 16'hBCDE, 8'hF0, 16'd1, 1'b1);
		chunk_pct = 10;
	endtask

	// The receiver holds off long enough for the block to fill up and stall its input while
	// the sender keeps offering short frames.
	task automatic test_backpressure();
		wait_drain();
		hold_request = 300;
		repeat (4)
			send_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
				8'($urandom_range(0, 255)), 16'd0, $urandom_range(0, 1));
		wait_drain();
	endtask

	// The longest length the header allows gives the widest character total. The frame is
	// cut off by a link drop early in its body, so it must not report, and a short frame
	// right after it shows the parser is back to hunting.
	task automatic test_max_length_frame();
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		send_frame(8'hA5, 16'h5AA5, 8'h3C, 16'hFFFF, 1'b0, -1, -1, 60);
		send_frame(8'h5A, 16'hA55A, 8'hC3, 16'd1, 1'b0);
		wait_drain();
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
	endtask

	// Mostly well-formed frames with random content, mixed with broken frames and noise.
	task automatic test_random_traffic();
		int kind;
		int len;
		int last_char;
		repeat (8) begin
			// Switch idling on and off now and then so that quiet stretches occur too.
			if ($urandom_range(0, 7) == 0) begin
				send_gaps = $urandom_range(0, 1);
				recv_gaps = $urandom_range(0, 1);
			end
			kind = $urandom_range(0, 99);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
			last_char = 18 + 2 * len;
			if (kind < 60)
				send_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
					8'($urandom_range(0, 255)), 16'(len), $urandom_range(0, 2) == 0);
			else if (kind < 70)
				send_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
					8'($urandom_range(0, 255)), 16'(len), 1'b0,
					$urandom_range(15, last_char));
			else if (kind < 78)
				send_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
					8'($urandom_range(0, 255)), 16'(len), 1'b0, $urandom_range(1, 14));
			else if (kind < 85)
				send_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
					8'($urandom_range(0, 255)), 16'(len), 1'b0, -1, -1,
					$urandom_range(0, last_char));
			else if (kind < 93)
				send_noise();
			else
				send_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
					8'($urandom_range(0, 255)), 16'(len), 1'b0, -1,
					$urandom_range(1, last_char));
		end
		wait_drain();
	endtask

	// Closing stretch at full rate on both sides.
	task automatic test_steady_stream();
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		repeat (6)
			send_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
				8'($urandom_range(0, 255)), 16'($urandom_range(0, 4)),
				$urandom_range(0, 3) == 0);
		wait_drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_in = 8'h00;
		chunk_end = 1'b0;
		link_drop = 1'b0;
		parser_clear();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed_cases();
		wait_drain();
		test_backpressure();
		test_max_length_frame();
		test_random_traffic();
		test_steady_stream();
		if (mismatch_count == 0)
			$display("hex_text_frame_deframer_test passed");
		else
			$display("hex_text_frame_deframer_test failed");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run under the longest stalls.
	initial begin
		#15_000_000;
		$display("hex_text_frame_deframer_test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/htfd_pkg.sv
hdl/htfd_parser.sv
hdl/hex_text_frame_deframer.sv
tb/hex_text_frame_deframer_test.sv
